// ===== hdl/tlt_pkg.sv =====
`timescale 1ns / 1ps

package tlt_pkg;

   // Width of the handshake tick counter.
   localparam int COUNT_BITS = 20;

   // Width of the timeout registers.
   localparam int REG_BITS = 20;

   // Width used to compare the counter against a timeout limit.
   localparam int CMP_BITS = ((COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS) + 1;

   // The counter gives up when it reaches the top of its range.
   localparam logic [COUNT_BITS:0] COUNT_TOP = {1'b0, {COUNT_BITS{1'b1}}};

   localparam logic [REG_BITS-1:0] HANDSHAKE_TIMEOUT_RESET = REG_BITS'(500000);
   localparam logic [REG_BITS-1:0] PROBE_TIMEOUT_RESET     = REG_BITS'(1024);

   // Register indexes on the configuration port.
   localparam logic CSR_HANDSHAKE_TIMEOUT = 1'b0;
   localparam logic CSR_PROBE_TIMEOUT     = 1'b1;

   // Result codes. Codes one to three name the tribble that timed out.
   localparam logic [2:0] RES_OK        = 3'd0;
   localparam logic [2:0] RES_NOT_FOUND = 3'd4;

   typedef enum logic [1:0] {
      FUNC_NONE    = 2'd0,
      FUNC_SEND    = 2'd1,
      FUNC_RECEIVE = 2'd2,
      FUNC_PROBE   = 2'd3
   } func_type;

   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_PROBE    = 7'b0000010,
      PH_RX_STB   = 7'b0000100,
      PH_RX_UNSTB = 7'b0001000,
      PH_TX_FREE  = 7'b0010000,
      PH_TX_SETUP = 7'b0100000,
      PH_TX_ACK   = 7'b1000000
   } phase_type;

   // Lines that we drive toward the partner.
   typedef struct packed {
      logic       busy;
      logic       strobe;
      logic [2:0] data;
   } line_type;

   localparam line_type LINE_IDLE = '{busy: 1'b1, strobe: 1'b0, data: 3'd0};
   localparam line_type LINE_LOW  = '{busy: 1'b0, strobe: 1'b0, data: 3'd0};

   // One input word: a request and the sampled partner lines.
   typedef struct packed {
      func_type   func;
      logic [7:0] tx_byte;
      logic       strobe_in;
      logic       busy_in;
      logic [2:0] tribble_in;
   } req_item_type;

   // One result word.
   typedef struct packed {
      logic       busy_out;
      logic       strobe_out;
      logic [2:0] data_out;
      logic       ready_res;
      logic       done_res;
      logic [2:0] result_code;
      logic [7:0] rx_byte;
   } rsp_item_type;

endpackage

// ===== hdl/tlt_in_reg.sv =====
`timescale 1ns / 1ps

module tlt_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tlt_pkg::req_item_type req_item,
   input  logic                  down_ready,
   output logic                  step_en,
   output tlt_pkg::req_item_type step_item
);

   logic                  full_ff;
   logic                  full_in;
   tlt_pkg::req_item_type item_ff;
   logic                  take;

   // The held word moves on whenever the result register can take it.
   assign step_en   = full_ff & down_ready;
   assign req_stall = full_ff & ~down_ready;
   assign take      = req_valid & ~req_stall;
   assign step_item = item_ff;

   always_comb begin
      full_in = full_ff;
      if (take) begin
         full_in = 1'b1;
      end else if (step_en) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== hdl/tlt_fsm.sv =====
`timescale 1ns / 1ps

module tlt_fsm (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_en,
   input  tlt_pkg::req_item_type               step_item,
   input  logic [tlt_pkg::REG_BITS-1:0]        handshake_timeout,
   input  logic [tlt_pkg::REG_BITS-1:0]        probe_timeout,
   output tlt_pkg::rsp_item_type               step_result
);

   tlt_pkg::phase_type                 phase_ff;
   tlt_pkg::phase_type                 phase_in;
   tlt_pkg::func_type                  operation_ff;
   tlt_pkg::func_type                  operation_in;
   logic [1:0]                         index_ff;
   logic [1:0]                         index_in;
   logic [tlt_pkg::COUNT_BITS-1:0]     wait_ff;
   logic [tlt_pkg::COUNT_BITS-1:0]     wait_in;
   logic [7:0]                         shift_ff;
   logic [7:0]                         shift_in;
   tlt_pkg::line_type                  line_ff;
   tlt_pkg::line_type                  line_in;

   logic [tlt_pkg::COUNT_BITS:0]       tick;
   logic [tlt_pkg::REG_BITS-1:0]       limit;
   logic                               expired;
   logic [tlt_pkg::COUNT_BITS-1:0]     wait_step;
   logic [2:0]                         timeout_code;
   logic [2:0]                         tx_tribble;
   logic [7:0]                         rx_merge;
   logic [1:0]                         index_inc;
   logic                               stb_low;
   logic                               done;
   logic [2:0]                         code;
   logic [7:0]                         rx;

   assign stb_low      = ~step_item.strobe_in;
   assign index_inc    = index_ff + 2'd1;
   assign timeout_code = {1'b0, index_ff} + 3'd1;

   // One failed tick: raise the count, or give up at the limit or counter top.
   assign tick    = {1'b0, wait_ff} + {{tlt_pkg::COUNT_BITS{1'b0}}, 1'b1};
   assign limit   = (phase_ff == tlt_pkg::PH_PROBE) ? probe_timeout : handshake_timeout;
   assign expired = (tlt_pkg::CMP_BITS'(tick) >= tlt_pkg::CMP_BITS'(limit)) ||
                    (tick >= tlt_pkg::COUNT_TOP);
   assign wait_step = expired ? '0 : tick[tlt_pkg::COUNT_BITS-1:0];

   // Tribble to send: low bits, middle bits, then the top two bits.
   always_comb begin
      case (index_ff)
         2'd0:    tx_tribble = shift_ff[2:0];
         2'd1:    tx_tribble = shift_ff[5:3];
         2'd2:    tx_tribble = {1'b0, shift_ff[7:6]};
         default: tx_tribble = 3'd0;
      endcase
   end

   // Received tribble merged into its place in the byte.
   always_comb begin
      case (index_ff)
         2'd0:    rx_merge = shift_ff | {5'd0, step_item.tribble_in};
         2'd1:    rx_merge = shift_ff | {2'd0, step_item.tribble_in, 3'd0};
         2'd2:    rx_merge = shift_ff | {step_item.tribble_in[1:0], 6'd0};
         default: rx_merge = shift_ff;
      endcase
   end

   // Next state for one tick.
   always_comb begin
      phase_in     = phase_ff;
      operation_in = operation_ff;
      index_in     = index_ff;
      wait_in      = wait_ff;
      shift_in     = shift_ff;
      line_in      = line_ff;
      done         = 1'b0;
      code         = tlt_pkg::RES_OK;
      rx           = 8'd0;
      case (phase_ff)
         tlt_pkg::PH_IDLE: begin
            if (step_item.func != tlt_pkg::FUNC_NONE) begin
               operation_in = step_item.func;
               index_in     = 2'd0;
               wait_in      = '0;
               if (step_item.func == tlt_pkg::FUNC_SEND) begin
                  shift_in = step_item.tx_byte;
                  line_in  = tlt_pkg::LINE_IDLE;
                  phase_in = tlt_pkg::PH_TX_FREE;
               end else begin
                  shift_in = 8'd0;
                  line_in  = tlt_pkg::LINE_LOW;
                  phase_in = (step_item.func == tlt_pkg::FUNC_RECEIVE) ?
                             tlt_pkg::PH_RX_STB : tlt_pkg::PH_PROBE;
               end
            end
         end
         tlt_pkg::PH_PROBE: begin
            if (stb_low) begin
               done     = 1'b1;
               phase_in = tlt_pkg::PH_IDLE;
            end else begin
               wait_in = wait_step;
               if (expired) begin
                  line_in  = tlt_pkg::LINE_IDLE;
                  done     = 1'b1;
                  code     = tlt_pkg::RES_NOT_FOUND;
                  phase_in = tlt_pkg::PH_IDLE;
               end
            end
         end
         tlt_pkg::PH_RX_STB: begin
            if (stb_low) begin
               shift_in = rx_merge;
               line_in  = tlt_pkg::LINE_IDLE;
               wait_in  = '0;
               phase_in = tlt_pkg::PH_RX_UNSTB;
            end else begin
               wait_in = wait_step;
               if (expired) begin
                  line_in  = tlt_pkg::LINE_IDLE;
                  done     = 1'b1;
                  code     = timeout_code;
                  phase_in = tlt_pkg::PH_IDLE;
               end
            end
         end
         tlt_pkg::PH_RX_UNSTB: begin
            if (!stb_low) begin
               index_in = index_inc;
               wait_in  = '0;
               if (index_inc == 2'd3) begin
                  done     = 1'b1;
                  rx       = shift_ff;
                  phase_in = tlt_pkg::PH_IDLE;
               end else begin
                  line_in  = tlt_pkg::LINE_LOW;
                  phase_in = tlt_pkg::PH_RX_STB;
               end
            end else begin
               wait_in = wait_step;
               if (expired) begin
                  done     = 1'b1;
                  code     = timeout_code;
                  phase_in = tlt_pkg::PH_IDLE;
               end
            end
         end
         tlt_pkg::PH_TX_FREE: begin
            if (!step_item.busy_in) begin
               line_in  = '{busy: 1'b0, strobe: 1'b0, data: tx_tribble};
               phase_in = tlt_pkg::PH_TX_SETUP;
            end else begin
               wait_in = wait_step;
               if (expired) begin
                  line_in  = tlt_pkg::LINE_IDLE;
                  done     = 1'b1;
                  code     = timeout_code;
                  phase_in = tlt_pkg::PH_IDLE;
               end
            end
         end
         tlt_pkg::PH_TX_SETUP: begin
            line_in  = '{busy: 1'b0, strobe: 1'b1, data: tx_tribble};
            wait_in  = '0;
            phase_in = tlt_pkg::PH_TX_ACK;
         end
         tlt_pkg::PH_TX_ACK: begin
            if (step_item.busy_in) begin
               line_in  = tlt_pkg::LINE_IDLE;
               index_in = index_inc;
               wait_in  = '0;
               if (index_inc == 2'd3) begin
                  done     = 1'b1;
                  phase_in = tlt_pkg::PH_IDLE;
               end else begin
                  phase_in = tlt_pkg::PH_TX_FREE;
               end
            end else begin
               wait_in = wait_step;
               if (expired) begin
                  line_in  = tlt_pkg::LINE_IDLE;
                  done     = 1'b1;
                  code     = timeout_code;
                  phase_in = tlt_pkg::PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = tlt_pkg::PH_IDLE;
         end
      endcase
   end

   // The result shows the lines and phase after this tick.
   always_comb begin
      step_result.busy_out    = line_in.busy;
      step_result.strobe_out  = line_in.strobe;
      step_result.data_out    = line_in.data;
      step_result.ready_res   = (phase_in == tlt_pkg::PH_IDLE);
      step_result.done_res    = done;
      step_result.result_code = done ? code : tlt_pkg::RES_OK;
      step_result.rx_byte     = (done && operation_ff == tlt_pkg::FUNC_RECEIVE) ? rx : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tlt_pkg::PH_IDLE;
         operation_ff <= tlt_pkg::FUNC_NONE;
         index_ff     <= 2'd0;
         wait_ff      <= '0;
         shift_ff     <= 8'd0;
         line_ff      <= tlt_pkg::LINE_IDLE;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         operation_ff <= operation_in;
         index_ff     <= index_in;
         wait_ff      <= wait_in;
         shift_ff     <= shift_in;
         line_ff      <= line_in;
      end
   end

endmodule

// ===== hdl/tlt_out_reg.sv =====
`timescale 1ns / 1ps

module tlt_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tlt_pkg::rsp_item_type load_item,
   output logic                  down_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tlt_pkg::rsp_item_type rsp_item
);

   logic                  valid_ff;
   logic                  valid_in;
   tlt_pkg::rsp_item_type item_ff;

   // A new word may enter when the register is empty or being read.
   assign down_ready = ~valid_ff | ~rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

// ===== hdl/tribble_link_transceiver_top.sv =====
`timescale 1ns / 1ps

// Tribble link transceiver. Each word on the req_ channel is one tick of the
// link: the sampled partner lines plus an optional request (send, receive or
// probe), and each produces exactly one rsp_ word with the lines we drive, the
// ready and done flags, the result code and the received byte. A word is
// taken in every cycle unless the rsp_ side stalls. Its result passes
// through the input register and the result register around the single-tick
// state update. Timeouts count words, not clock cycles, so stalls do not age
// a wait. The user is to write the timeout registers through csr_ while no
// request is running; the block itself does not enforce this.

module tribble_link_transceiver_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [tlt_pkg::REG_BITS-1:0]     csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_func,
   input  logic [7:0]                       req_tx_byte,
   input  logic                             req_strobe_in,
   input  logic                             req_busy_in,
   input  logic [2:0]                       req_tribble_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_busy_out,
   output logic                             rsp_strobe_out,
   output logic [2:0]                       rsp_data_out,
   output logic                             rsp_ready_res,
   output logic                             rsp_done_res,
   output logic [2:0]                       rsp_result_code,
   output logic [7:0]                       rsp_rx_byte
);

   logic [tlt_pkg::REG_BITS-1:0] handshake_timeout_ff;
   logic [tlt_pkg::REG_BITS-1:0] probe_timeout_ff;
   tlt_pkg::req_item_type        req_item;
   tlt_pkg::req_item_type        step_item;
   tlt_pkg::rsp_item_type        step_result;
   tlt_pkg::rsp_item_type        rsp_item;
   logic                         step_en;
   logic                         down_ready;

   // Timeout registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         handshake_timeout_ff <= tlt_pkg::HANDSHAKE_TIMEOUT_RESET;
         probe_timeout_ff     <= tlt_pkg::PROBE_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == tlt_pkg::CSR_HANDSHAKE_TIMEOUT) begin
            handshake_timeout_ff <= csr_wr_data;
         end
         if (csr_index == tlt_pkg::CSR_PROBE_TIMEOUT) begin
            probe_timeout_ff <= csr_wr_data;
         end
      end
   end

   // Gather the input word.
   always_comb begin
      req_item.func       = tlt_pkg::func_type'(req_func);
      req_item.tx_byte    = req_tx_byte;
      req_item.strobe_in  = req_strobe_in;
      req_item.busy_in    = req_busy_in;
      req_item.tribble_in = req_tribble_in;
   end

   tlt_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .down_ready (down_ready),
      .step_en    (step_en),
      .step_item  (step_item)
   );

   tlt_fsm u_fsm (
      .clock             (clock),
      .reset             (reset),
      .step_en           (step_en),
      .step_item         (step_item),
      .handshake_timeout (handshake_timeout_ff),
      .probe_timeout     (probe_timeout_ff),
      .step_result       (step_result)
   );

   tlt_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step_en),
      .load_item  (step_result),
      .down_ready (down_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   // Split the result word onto its ports.
   assign rsp_busy_out    = rsp_item.busy_out;
   assign rsp_strobe_out  = rsp_item.strobe_out;
   assign rsp_data_out    = rsp_item.data_out;
   assign rsp_ready_res   = rsp_item.ready_res;
   assign rsp_done_res    = rsp_item.done_res;
   assign rsp_result_code = rsp_item.result_code;
   assign rsp_rx_byte     = rsp_item.rx_byte;

   // A finished request always leaves the block idle.
   a_done_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_ready_res)
      else $error("done reported while not idle");

   // A received byte only appears with a successful completion.
   a_rx_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_rx_byte != 8'd0) |->
         rsp_done_res && (rsp_result_code == tlt_pkg::RES_OK))
      else $error("received byte without successful completion");

   // A result code is only given with done.
   a_code_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_code != tlt_pkg::RES_OK) |-> rsp_done_res)
      else $error("result code without done");

   // Strobe is only driven while busy is dropped.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_strobe_out |-> !rsp_busy_out && !rsp_ready_res)
      else $error("strobe driven with busy raised or while idle");

endmodule

// ===== test/tribble_link_transceiver_top_tb.sv =====
`timescale 1ns / 1ps

module tribble_link_transceiver_top_tb;
   import tlt_pkg::*;

   localparam int CLOCK_HALF    = 2;
   localparam int RESET_CYCLES  = 10;
   localparam int MAX_GAP       = 13;
   localparam int LONG_HOLD     = 60;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 3000;
   localparam int PHASE_TICKS   = 145;
   localparam int PHASE_COUNT   = 6;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic                csr_index   = CSR_HANDSHAKE_TIMEOUT;
   logic [REG_BITS-1:0] csr_wr_data = '0;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_item_type        req_word    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic                rsp_busy_out;
   logic                rsp_strobe_out;
   logic [2:0]          rsp_data_out;
   logic                rsp_ready_res;
   logic                rsp_done_res;
   logic [2:0]          rsp_result_code;
   logic [7:0]          rsp_rx_byte;

   // Link state as the block should hold it.
   phase_type           link_phase      = PH_IDLE;
   func_type            link_func       = FUNC_NONE;
   logic [1:0]          tribble_num     = '0;
   logic [31:0]         wait_ticks      = '0;
   logic [7:0]          link_byte       = '0;
   line_type            link_lines      = LINE_IDLE;
   logic [REG_BITS-1:0] handshake_limit = HANDSHAKE_TIMEOUT_RESET;
   logic [REG_BITS-1:0] probe_limit     = PROBE_TIMEOUT_RESET;

   req_item_type tick_queue[$];
   rsp_item_type tick_results[$];

   int ticks_queued  = 0;
   int ticks_taken   = 0;
   int results_seen  = 0;
   int fail_count    = 0;
   int ok_count      = 0;
   int timeout_count = 0;
   int missing_count = 0;
   int send_wait     = 0;
   int rsp_wait      = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   int idle_cycles   = 0;
   bit req_taken     = 1'b0;
   bit rsp_taken     = 1'b0;
   bit sender_gaps   = 1'b1;
   bit receiver_gaps = 1'b1;

   tribble_link_transceiver_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_word.func),
      .req_tx_byte     (req_word.tx_byte),
      .req_strobe_in   (req_word.strobe_in),
      .req_busy_in     (req_word.busy_in),
      .req_tribble_in  (req_word.tribble_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_busy_out    (rsp_busy_out),
      .rsp_strobe_out  (rsp_strobe_out),
      .rsp_data_out    (rsp_data_out),
      .rsp_ready_res   (rsp_ready_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_result_code (rsp_result_code),
      .rsp_rx_byte     (rsp_rx_byte)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Counts one tick of a failed wait and tells whether the wait has run out.
   // A limit of zero gives up on the first tick, as a limit of one does.
   function automatic logic wait_expired(input logic [REG_BITS-1:0] limit);
      logic [31:0] next_count;
      next_count = wait_ticks + 32'd1;
      if (next_count >= 32'(limit) || next_count >= 32'(COUNT_TOP)) begin
         wait_ticks = '0;
         return 1'b1;
      end
      wait_ticks = next_count;
      return 1'b0;
   endfunction

   // Advances the link by one tick and files the result word it should give.
   task automatic step_link(input req_item_type w);
      rsp_item_type r;
      logic         strobe_seen;
      logic         done;
      logic [2:0]   code;
      logic [7:0]   rx;
      logic [2:0]   chunk;
      logic [2:0]   tx_bits;
      strobe_seen = !w.strobe_in;
      done        = 1'b0;
      code        = RES_OK;
      rx          = '0;
      tx_bits     = 3'(link_byte >> (3 * tribble_num));
      case (link_phase)
         PH_IDLE: begin
            if (w.func != FUNC_NONE) begin
               link_func   = w.func;
               tribble_num = '0;
               wait_ticks  = '0;
               if (w.func == FUNC_SEND) begin
                  link_byte  = w.tx_byte;
                  link_lines = LINE_IDLE;
                  link_phase = PH_TX_FREE;
               end else begin
                  link_byte  = '0;
                  link_lines = LINE_LOW;
                  link_phase = (w.func == FUNC_RECEIVE) ? PH_RX_STB : PH_PROBE;
               end
            end
         end
         PH_PROBE: begin
            if (strobe_seen) begin
               done       = 1'b1;
               link_phase = PH_IDLE;
            end else if (wait_expired(probe_limit)) begin
               link_lines = LINE_IDLE;
               done       = 1'b1;
               code       = RES_NOT_FOUND;
               link_phase = PH_IDLE;
            end
         end
         PH_RX_STB: begin
            if (strobe_seen) begin
               // The last tribble carries only the top two bits of the byte.
               chunk      = (tribble_num == 2'd2) ? {1'b0, w.tribble_in[1:0]} : w.tribble_in;
               link_byte  = link_byte | (8'(chunk) << (3 * tribble_num));
               link_lines = LINE_IDLE;
               wait_ticks = '0;
               link_phase = PH_RX_UNSTB;
            end else if (wait_expired(handshake_limit)) begin
               link_lines = LINE_IDLE;
               done       = 1'b1;
               code       = {1'b0, tribble_num} + 3'd1;
               link_phase = PH_IDLE;
            end
         end
         PH_RX_UNSTB: begin
            if (!strobe_seen) begin
               tribble_num = tribble_num + 2'd1;
               wait_ticks  = '0;
               if (tribble_num == 2'd3) begin
                  done       = 1'b1;
                  rx         = link_byte;
                  link_phase = PH_IDLE;
               end else begin
                  link_lines = LINE_LOW;
                  link_phase = PH_RX_STB;
               end
            end else if (wait_expired(handshake_limit)) begin
               // Busy is already raised here and stays so.
               done       = 1'b1;
               code       = {1'b0, tribble_num} + 3'd1;
               link_phase = PH_IDLE;
            end
         end
         PH_TX_FREE: begin
            if (!w.busy_in) begin
               link_lines      = LINE_LOW;
               link_lines.data = tx_bits;
               link_phase      = PH_TX_SETUP;
            end else if (wait_expired(handshake_limit)) begin
               link_lines = LINE_IDLE;
               done       = 1'b1;
               code       = {1'b0, tribble_num} + 3'd1;
               link_phase = PH_IDLE;
            end
         end
         PH_TX_SETUP: begin
            link_lines        = LINE_LOW;
            link_lines.data   = tx_bits;
            link_lines.strobe = 1'b1;
            wait_ticks        = '0;
            link_phase        = PH_TX_ACK;
         end
         PH_TX_ACK: begin
            if (w.busy_in) begin
               link_lines  = LINE_IDLE;
               tribble_num = tribble_num + 2'd1;
               wait_ticks  = '0;
               link_phase  = (tribble_num == 2'd3) ? PH_IDLE : PH_TX_FREE;
               done        = (tribble_num == 2'd3);
            end else if (wait_expired(handshake_limit)) begin
               link_lines = LINE_IDLE;
               done       = 1'b1;
               code       = {1'b0, tribble_num} + 3'd1;
               link_phase = PH_IDLE;
            end
         end
         default: begin
            link_phase = PH_IDLE;
         end
      endcase
      if (done && link_func != FUNC_RECEIVE) begin
         rx = '0;
      end
      r.busy_out    = link_lines.busy;
      r.strobe_out  = link_lines.strobe;
      r.data_out    = link_lines.data;
      r.ready_res   = (link_phase == PH_IDLE);
      r.done_res    = done;
      r.result_code = done ? code : RES_OK;
      r.rx_byte     = rx;
      tick_results.push_back(r);
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Every accepted request word moves the link state on by one tick.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         step_link(req_word);
         ticks_taken++;
      end
   end

   // Each accepted result word is held against the oldest pending tick.
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (tick_results.size() == 0) begin
            $error("result word arrived with no tick pending");
            fail_count++;
         end else begin
            want = tick_results.pop_front();
            check_field("busy_out", want.busy_out, rsp_busy_out);
            check_field("strobe_out", want.strobe_out, rsp_strobe_out);
            check_field("data_out", want.data_out, rsp_data_out);
            check_field("ready_res", want.ready_res, rsp_ready_res);
            check_field("done_res", want.done_res, rsp_done_res);
            check_field("result_code", want.result_code, rsp_result_code);
            check_field("rx_byte", want.rx_byte, rsp_rx_byte);
            if (want.done_res) begin
               if (want.result_code == RES_OK) begin
                  ok_count++;
               end else if (want.result_code == RES_NOT_FOUND) begin
                  missing_count++;
               end else begin
                  timeout_count++;
               end
            end
         end
      end
   end

   // Request driver: one word from the queue, then a random pause after it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_wait != 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (tick_queue.size() != 0) begin
            req_word  <= tick_queue.pop_front();
            req_valid <= 1'b1;
            send_wait <= sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: a random stall after each word, or a long hold when one is asked for.
   always @(negedge clock) begin : result_pacing
      int draw;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         rsp_wait     <= LONG_HOLD - 1;
         rsp_stall    <= 1'b1;
      end else if (rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_taken) begin
         draw      = receiver_gaps ? $urandom_range(0, MAX_GAP) : 0;
         rsp_wait  <= (draw == 0) ? 0 : draw - 1;
         rsp_stall <= (draw != 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles where neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tribble_link_transceiver_top_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_item_type random_tick();
      req_item_type w;
      w.func       = func_type'($urandom_range(0, 3));
      w.tx_byte    = 8'($urandom);
      w.strobe_in  = 1'($urandom);
      w.busy_in    = 1'($urandom);
      w.tribble_in = 3'($urandom);
      return w;
   endfunction

   task automatic queue_tick(input req_item_type w);
      tick_queue.push_back(w);
      ticks_queued++;
   endtask

   task automatic queue_request(input func_type f, input logic [7:0] value);
      req_item_type w;
      w         = random_tick();
      w.func    = f;
      w.tx_byte = value;
      queue_tick(w);
   endtask

   task automatic queue_busy(input logic level);
      req_item_type w;
      w         = random_tick();
      w.busy_in = level;
      queue_tick(w);
   endtask

   task automatic queue_strobe(input logic level, input logic [2:0] data);
      req_item_type w;
      w            = random_tick();
      w.strobe_in  = level;
      w.tribble_in = data;
      queue_tick(w);
   endtask

   // Partner side of a send: drop busy, see the strobe, raise busy, per tribble.
   task automatic send_seq(input logic [7:0] value, input int tribbles, input int max_wait);
      int t;
      queue_request(FUNC_SEND, value);
      for (t = 0; t < tribbles; t++) begin
         repeat ($urandom_range(0, max_wait)) queue_busy(1'b1);
         queue_busy(1'b0);
         queue_tick(random_tick());
         repeat ($urandom_range(0, max_wait)) queue_busy(1'b0);
         queue_busy(1'b1);
      end
   endtask

   // Partner side of a receive: strobe with the tribble, then release it.
   task automatic recv_seq(input logic [7:0] value, input int tribbles, input int max_wait);
      int         t;
      logic [2:0] chunk;
      queue_request(FUNC_RECEIVE, 8'($urandom));
      for (t = 0; t < tribbles; t++) begin
         chunk = (t == 2) ? {1'($urandom), value[7:6]} : 3'(value >> (3 * t));
         repeat ($urandom_range(0, max_wait)) queue_strobe(1'b1, 3'($urandom));
         queue_strobe(1'b0, chunk);
         repeat ($urandom_range(0, max_wait)) queue_strobe(1'b0, 3'($urandom));
         queue_strobe(1'b1, 3'($urandom));
      end
   endtask

   task automatic probe_seq(input int max_wait, input logic answered);
      queue_request(FUNC_PROBE, 8'($urandom));
      repeat ($urandom_range(0, max_wait)) queue_strobe(1'b1, 3'($urandom));
      if (answered) begin
         queue_strobe(1'b0, 3'($urandom));
      end
   endtask

   task automatic wait_taken();
      while (ticks_taken != ticks_queued) @(negedge clock);
   endtask

   // Feeds the partner lines that finish whatever request is open, one word at a time.
   task automatic settle_link();
      req_item_type w;
      wait_taken();
      while (link_phase != PH_IDLE) begin
         w = random_tick();
         case (link_phase)
            PH_PROBE, PH_RX_STB: w.strobe_in = 1'b0;
            PH_RX_UNSTB:         w.strobe_in = 1'b1;
            PH_TX_FREE:          w.busy_in   = 1'b0;
            PH_TX_ACK:           w.busy_in   = 1'b1;
            default: ;
         endcase
         queue_tick(w);
         wait_taken();
      end
   endtask

   // Brings the link to idle and lets every pending result word come back.
   task automatic drain_link();
      settle_link();
      while (tick_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic which, input logic [REG_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= which;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (which == CSR_HANDSHAKE_TIMEOUT) begin
         handshake_limit = data;
      end else begin
         probe_limit = data;
      end
   endtask

   initial begin : stimulus
      logic [REG_BITS-1:0] hs_value;
      logic [REG_BITS-1:0] pb_value;
      logic [7:0]          value;
      int                  p;
      int                  pick;
      int                  phase_end;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset timeouts: full bytes both ways, a probe, a quiet tick, then a zero byte received.
      send_seq(8'hFF, 3, 0);
      recv_seq(8'hFF, 3, 0);
      probe_seq(0, 1'b1);
      queue_request(FUNC_NONE, 8'h00);
      recv_seq(8'h00, 3, 0);

      for (p = 0; p < PHASE_COUNT; p++) begin
         drain_link();
         case (p)
            0: begin
               hs_value = REG_BITS'(1);
               pb_value = REG_BITS'(1);
            end
            1: begin
               hs_value = '0;
               pb_value = '0;
            end
            2: begin
               hs_value = REG_BITS'(3);
               pb_value = REG_BITS'(6);
            end
            3: begin
               hs_value = '1;
               pb_value = '1;
            end
            4: begin
               hs_value = REG_BITS'($urandom_range(1, 8));
               pb_value = REG_BITS'($urandom_range(1, 8));
            end
            default: begin
               hs_value = REG_BITS'($urandom_range(2, 6));
               pb_value = REG_BITS'($urandom_range(1, 4));
            end
         endcase
         write_csr(CSR_HANDSHAKE_TIMEOUT, hs_value);
         write_csr(CSR_PROBE_TIMEOUT, pb_value);

         if (p == 0) begin
            // With one-tick limits: a probe nobody answers, and first-tribble timeouts.
            queue_request(FUNC_PROBE, 8'h00);
            queue_strobe(1'b1, 3'd0);
            queue_request(FUNC_RECEIVE, 8'h00);
            queue_strobe(1'b1, 3'd7);
            queue_request(FUNC_SEND, 8'hA5);
            queue_busy(1'b1);
         end else if (p == 3) begin
            // Hold results back while the sender keeps offering words.
            sender_gaps   = 1'b0;
            receiver_gaps = 1'b0;
            holds_asked++;
            send_seq(8'($urandom), 3, 0);
            recv_seq(8'($urandom), 3, 0);
            send_seq(8'($urandom), 3, 0);
         end

         phase_end = ticks_queued + PHASE_TICKS;
         while (ticks_queued < phase_end) begin
            sender_gaps   = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
            settle_link();
            value = ($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
            pick  = $urandom_range(0, 9);
            case (pick)
               0, 1, 2: send_seq(value, 3, 4);
               3, 4, 5: recv_seq(value, 3, 4);
               6, 7:    probe_seq(4, 1'b1);
               8:       repeat ($urandom_range(1, 4)) queue_tick(random_tick());
               default: begin
                  // A sequence cut short, followed by line noise.
                  case ($urandom_range(0, 2))
                     0:       send_seq(value, $urandom_range(0, 2), 4);
                     1:       recv_seq(value, $urandom_range(0, 2), 4);
                     default: probe_seq(4, 1'b0);
                  endcase
                  repeat ($urandom_range(0, 3)) queue_tick(random_tick());
               end
            endcase
         end
      end

      drain_link();
      if (tick_results.size() != 0) begin
         $error("%0d result words never arrived", tick_results.size());
         fail_count++;
      end
      $display("Checked %0d result words from %0d link ticks over %0d timeout settings.",
               results_seen, ticks_taken, PHASE_COUNT + 1);
      $display("Requests finished: %0d ok, %0d tribble timeouts, %0d probes unanswered.",
               ok_count, timeout_count, missing_count);
      if (fail_count == 0) begin
         $display("tribble_link_transceiver_top_tb passed");
      end else begin
         $display("tribble_link_transceiver_top_tb failed");
      end
      $finish;
   end

endmodule
